[hw/rtl/i2c_master_transfer_sequencer_unit_macros.svh]
// ----------------------------------------------------------------------------
// i2c master transfer sequencer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

// checked only outside reset
`define I2CMTS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("i2cmts assertion failed");

// checked at every edge, reset included
`define I2CMTS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("i2cmts assertion failed");

`endif

[hw/rtl/i2cmts_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmts_pkg
// types, codes and widths shared by the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cmts_pkg;

	localparam int BUF_DEPTH_DEF = 256;
	localparam int KIND_W        = 2;
	localparam int IN_DATA_W     = 56;
	localparam int OUT_DATA_W    = 40;
	localparam int RES_W         = 35;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_START = 2'd1,
		KIND_EVENT = 2'd2,
		KIND_POLL  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_BUSY    = 3'd1,
		ERR_BUS     = 3'd2,
		ERR_ARB     = 3'd3,
		ERR_NOSLAVE = 3'd4,
		ERR_UNEXP   = 3'd5,
		ERR_UNSUP   = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		ACK_KEEP  = 2'd0,
		ACK_SET   = 2'd1,
		ACK_CLEAR = 2'd2
	} ack_t;

	localparam logic [2:0] TT_READ       = 3'd0;
	localparam logic [2:0] TT_WRITE      = 3'd1;
	localparam logic [2:0] TT_READ_ABORT = 3'd2;
	localparam logic [2:0] TT_WRITE_NS   = 3'd3;

	localparam logic [7:0] SC_BUS_ERR  = 8'h00;
	localparam logic [7:0] SC_START    = 8'h08;
	localparam logic [7:0] SC_RSTART   = 8'h10;
	localparam logic [7:0] SC_AW_ACK   = 8'h18;
	localparam logic [7:0] SC_AW_NAK   = 8'h20;
	localparam logic [7:0] SC_DW_ACK   = 8'h28;
	localparam logic [7:0] SC_DW_NAK   = 8'h30;
	localparam logic [7:0] SC_ARB_LOST = 8'h38;
	localparam logic [7:0] SC_AR_ACK   = 8'h40;
	localparam logic [7:0] SC_AR_NAK   = 8'h48;
	localparam logic [7:0] SC_DR_ACK   = 8'h50;
	localparam logic [7:0] SC_DR_NAK   = 8'h58;

	localparam logic [7:0] ADDR_DIR_MASK = 8'hfe;

	typedef struct packed {
		logic [7:0] rx_data;
		logic [7:0] bus_status;
		logic [8:0] length;
		logic [7:0] address;
		logic [2:0] transfer_type;
		logic [7:0] buf_byte;
		logic [7:0] buf_index;
	} item_t;

	typedef struct packed {
		logic       busy_res;
		err_t       status;
		logic [7:0] rx_byte;
		logic [7:0] rx_index;
		logic       rx_valid;
		logic [7:0] tx_byte;
		logic       tx_valid;
		ack_t       ack_control;
		logic       set_stop;
		logic       clear_start;
		logic       set_start;
	} res_t;

endpackage

[hw/rtl/i2cmts_txbuf.sv]
// ----------------------------------------------------------------------------
// i2cmts_txbuf
// transmit byte store, one write port and one registered read port
// with write-to-read forwarding
// ----------------------------------------------------------------------------
module i2cmts_txbuf #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[hw/rtl/i2c_master_transfer_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// Status-code driven i2c master sequencer. Takes buffer loads, transfer
// starts, bus status events and polls, and returns one result per item with
// start, stop and acknowledge requests, the byte to send, the accepted
// received byte with its position, and a status. One item is accepted every
// clock cycle; its result passes through the input register, decode and the
// result register, and a result held by a stalled receiver holds off the
// input. The transmit buffer is a single-port-write memory whose read port is
// prefetched at the next byte position, so a data byte is ready when its
// acknowledge event is decoded. Errors are held until a poll or a start
// reports them. No clearing pass after reset: buffer entries are valid once
// loaded.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_unit #(
	parameter int BUF_DEPTH = i2cmts_pkg::BUF_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// buf_index, buf_byte, transfer_type, address, length, bus_status, rx_data
	input  logic [i2cmts_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind
	input  logic [i2cmts_pkg::KIND_W-1:0]       s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// set_start, clear_start, set_stop, ack_control, tx_valid, tx_byte,
	// rx_valid, rx_index, rx_byte, status, busy_res
	output logic [i2cmts_pkg::OUT_DATA_W-1:0]   m_tdata
);

	import i2cmts_pkg::*;

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(BUF_DEPTH - 1);

	function automatic logic [AW-1:0] wrap_idx(input logic [7:0] v);
		int r;
		r = int'(v);
		for (int k = 7; k >= 0; k--) begin
			if (r >= (BUF_DEPTH << k)) begin
				r = r - (BUF_DEPTH << k);
			end
		end
		return r[AW-1:0];
	endfunction

	logic          valid_s1;
	kind_t         kind_s1;
	item_t         item_s1;
	logic          fire;

	logic          out_valid_q;
	res_t          res_q;

	logic          busy_q, busy_d;
	err_t          pend_q, pend_d;
	logic          rmode_q, rmode_d;
	logic          aoz_q, aoz_d;
	logic [7:0]    taddr_q, taddr_d;
	logic [8:0]    tlen_q, tlen_d;
	logic [8:0]    bpos_q, bpos_d;
	logic [AW-1:0] ptr_q, ptr_d, rd_addr;
	logic          pos_zero, pos_inc;
	logic [8:0]    bpos_inc;
	logic          rx_take;
	logic          wr_en;
	logic [7:0]    rd_data;
	res_t          res;

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign bpos_inc = bpos_q + 9'd1;
	assign wr_en    = fire && (kind_s1 == KIND_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= kind_t'(s_tuser);
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	always_comb begin
		res      = '0;
		busy_d   = busy_q;
		pend_d   = pend_q;
		rmode_d  = rmode_q;
		aoz_d    = aoz_q;
		taddr_d  = taddr_q;
		tlen_d   = tlen_q;
		bpos_d   = bpos_q;
		pos_zero = 1'b0;
		pos_inc  = 1'b0;
		rx_take  = 1'b0;
		case (kind_s1)
			KIND_LOAD: begin
			end
			KIND_START: begin
				if (busy_q) begin
					res.status = ERR_BUSY;
				end else if (pend_q != ERR_NONE) begin
					res.status = pend_q;
					pend_d     = ERR_NONE;
				end else begin
					tlen_d   = item_s1.length;
					bpos_d   = 9'd0;
					pos_zero = 1'b1;
					aoz_d    = 1'b0;
					case (item_s1.transfer_type)
						TT_READ, TT_READ_ABORT: begin
							taddr_d = item_s1.address | 8'h01;
							rmode_d = 1'b1;
							aoz_d   = (item_s1.transfer_type == TT_READ_ABORT);
						end
						TT_WRITE, TT_WRITE_NS: begin
							taddr_d = item_s1.address & ADDR_DIR_MASK;
							rmode_d = 1'b0;
						end
						default: begin
							res.status = ERR_UNSUP;
						end
					endcase
					if (res.status == ERR_NONE) begin
						busy_d          = 1'b1;
						res.ack_control = ACK_CLEAR;
						res.set_start   = 1'b1;
					end
				end
			end
			KIND_EVENT: begin
				case (item_s1.bus_status)
					SC_BUS_ERR: begin
						pend_d = ERR_BUS; busy_d = 1'b0; res.status = ERR_BUS;
						res.clear_start = 1'b1; res.set_stop = 1'b1;
					end
					SC_START, SC_RSTART: begin
						res.clear_start = 1'b1;
						res.tx_valid    = 1'b1;
						res.tx_byte     = taddr_q;
						bpos_d          = 9'd0;
						pos_zero        = 1'b1;
					end
					SC_ARB_LOST: begin
						pend_d = ERR_ARB; busy_d = 1'b0; res.status = ERR_ARB;
						res.clear_start = 1'b1; res.set_stop = 1'b1;
					end
					SC_AW_ACK, SC_DW_ACK: begin
						if (bpos_q >= tlen_q) begin
							res.set_stop = 1'b1;
							busy_d       = 1'b0;
						end else begin
							res.tx_valid = 1'b1;
							if (!rmode_q) begin
								res.tx_byte = rd_data;
								bpos_d      = bpos_inc;
								pos_inc     = 1'b1;
							end
						end
					end
					SC_AW_NAK, SC_DW_NAK: begin
						pend_d = ERR_NOSLAVE; busy_d = 1'b0; res.status = ERR_NOSLAVE;
						res.clear_start = 1'b1; res.set_stop = 1'b1;
					end
					SC_AR_ACK: begin
						res.ack_control = ACK_SET;
					end
					SC_DR_ACK, SC_DR_NAK: begin
						rx_take = rmode_q && (bpos_q < tlen_q);
						if (rx_take) begin
							res.rx_valid = 1'b1;
							res.rx_index = bpos_q[7:0];
							res.rx_byte  = item_s1.rx_data;
							bpos_d       = bpos_inc;
							pos_inc      = 1'b1;
						end
						if (item_s1.bus_status == SC_DR_NAK) begin
							res.set_stop = 1'b1;
							busy_d       = 1'b0;
						end else if ((bpos_d >= tlen_q) || (aoz_q && (bpos_d == 9'd1)
								&& (item_s1.rx_data == 8'h00))) begin
							res.ack_control = ACK_CLEAR;
						end else begin
							res.ack_control = ACK_SET;
						end
					end
					SC_AR_NAK: begin
						pend_d = ERR_NOSLAVE; busy_d = 1'b0; res.status = ERR_NOSLAVE;
						res.set_stop = 1'b1;
					end
					default: begin
						pend_d = ERR_UNEXP; busy_d = 1'b0; res.status = ERR_UNEXP;
						res.clear_start = 1'b1;
					end
				endcase
			end
			KIND_POLL: begin
				if (busy_q) begin
					res.status = ERR_BUSY;
				end else if (pend_q != ERR_NONE) begin
					res.status = pend_q;
					pend_d     = ERR_NONE;
				end
			end
			default: begin
			end
		endcase
		res.busy_res = busy_d;
	end

	// buffer pointer tracks byte position modulo the buffer depth
	always_comb begin
		ptr_d = ptr_q;
		if (pos_zero || (pos_inc && (bpos_q == 9'h1ff))) begin
			ptr_d = '0;
		end else if (pos_inc) begin
			ptr_d = (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
		end
		rd_addr = fire ? ptr_d : ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= ERR_NONE;
			rmode_q     <= 1'b0;
			aoz_q       <= 1'b0;
			taddr_q     <= 8'h00;
			tlen_q      <= 9'd0;
			bpos_q      <= 9'd0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q  <= busy_d;
				pend_q  <= pend_d;
				rmode_q <= rmode_d;
				aoz_q   <= aoz_d;
				taddr_q <= taddr_d;
				tlen_q  <= tlen_d;
				bpos_q  <= bpos_d;
				ptr_q   <= ptr_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	i2cmts_txbuf #(
		.DEPTH (BUF_DEPTH),
		.AW    (AW)
	) u_txbuf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wrap_idx(item_s1.buf_index)),
		.wr_data (item_s1.buf_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - RES_W)'(0), res_q};

endmodule

[hw/rtl/i2cmts_checker.sv]
// ----------------------------------------------------------------------------
// i2cmts_checker
// port-level checks for the i2c master transfer sequencer, bound to the top
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_unit_macros.svh"

module i2cmts_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [i2cmts_pkg::IN_DATA_W-1:0]    s_tdata,
	input logic [i2cmts_pkg::KIND_W-1:0]       s_tuser,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [i2cmts_pkg::OUT_DATA_W-1:0]   m_tdata
);

	import i2cmts_pkg::*;

	// stalled result holds
	`I2CMTS_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// no result during reset
	`I2CMTS_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !m_tvalid)

	// an empty output side never blocks the input
	`I2CMTS_ASSERT(a_no_block, clk, arst_n, !m_tvalid |-> s_tready)

	// stop requests end the transfer
	`I2CMTS_ASSERT(a_stop_idle, clk, arst_n, m_tvalid && m_tdata[2] |-> !m_tdata[34])

	// busy refusal only while busy
	`I2CMTS_ASSERT(a_busy_stat, clk, arst_n, m_tvalid && (m_tdata[33:31] == ERR_BUSY) |-> m_tdata[34])

endmodule

bind i2c_master_transfer_sequencer_unit i2cmts_checker u_i2cmts_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: i2c master transfer sequencer testbench
// Drives buffer loads, transfer starts, bus status events and polls through
// the input stream, mostly as complete write and read transfers with random
// content and some noise. A scoreboard predicts each result and checks every
// result transfer field by field, under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmts_pkg::*;

	localparam int ITEMS_PER_PHASE = 300;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int DRAIN_LIMIT     = 5000;

	class transfer_scoreboard;
		bit         busy;
		err_t       pend_err;
		err_t       last_err;
		bit         rd_mode;
		bit         abort_zero;
		logic [7:0] tgt_addr;
		logic [8:0] xfer_len;
		logic [8:0] pos;
		logic [7:0] unexp_code;
		logic [7:0] txbuf [256];
		bit         loaded [256];
		res_t       pending_results [$];
		int         errors;
		int         checked;

		function new();
			busy       = 1'b0;
			pend_err   = ERR_NONE;
			last_err   = ERR_NONE;
			rd_mode    = 1'b0;
			abort_zero = 1'b0;
			tgt_addr   = '0;
			xfer_len   = '0;
			pos        = '0;
			unexp_code = '0;
			errors     = 0;
			checked    = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function void raise(err_t e, ref res_t r);
			pend_err = e;
			busy     = 1'b0;
			r.status = e;
		endfunction

		function res_t predict_result(kind_t k, item_t it);
			res_t r;
			bit   go;
			r  = '0;
			go = 1'b0;
			case (k)
				KIND_LOAD: begin
					txbuf[it.buf_index]  = it.buf_byte;
					loaded[it.buf_index] = 1'b1;
				end
				KIND_START: begin
					if (busy) begin
						r.status = ERR_BUSY;
					end else if (pend_err != ERR_NONE) begin
						r.status = pend_err;
						last_err = pend_err;
						pend_err = ERR_NONE;
					end else begin
						xfer_len   = it.length;
						pos        = '0;
						abort_zero = 1'b0;
						if (it.transfer_type == TT_READ || it.transfer_type == TT_READ_ABORT) begin
							tgt_addr   = it.address | 8'h01;
							rd_mode    = 1'b1;
							abort_zero = (it.transfer_type == TT_READ_ABORT);
							go         = 1'b1;
						end else if (it.transfer_type == TT_WRITE ||
								it.transfer_type == TT_WRITE_NS) begin
							tgt_addr = it.address & ADDR_DIR_MASK;
							rd_mode  = 1'b0;
							go       = 1'b1;
						end else begin
							last_err = ERR_UNSUP;
							r.status = ERR_UNSUP;
						end
						if (go) begin
							last_err      = ERR_NONE;
							busy          = 1'b1;
							r.ack_control = ACK_CLEAR;
							r.set_start   = 1'b1;
						end
					end
				end
				KIND_EVENT: begin
					case (it.bus_status)
						SC_BUS_ERR: begin
							raise(ERR_BUS, r);
							r.clear_start = 1'b1;
							r.set_stop    = 1'b1;
						end
						SC_START, SC_RSTART: begin
							r.clear_start = 1'b1;
							r.tx_valid    = 1'b1;
							r.tx_byte     = tgt_addr;
							pos           = '0;
						end
						SC_ARB_LOST: begin
							raise(ERR_ARB, r);
							r.clear_start = 1'b1;
							r.set_stop    = 1'b1;
						end
						SC_AW_ACK, SC_DW_ACK: begin
							if (pos >= xfer_len) begin
								r.set_stop = 1'b1;
								busy       = 1'b0;
							end else begin
								r.tx_valid = 1'b1;
								if (!rd_mode) begin
									r.tx_byte = txbuf[pos[7:0]];
									pos       = pos + 9'd1;
								end
							end
						end
						SC_AW_NAK, SC_DW_NAK: begin
							raise(ERR_NOSLAVE, r);
							r.clear_start = 1'b1;
							r.set_stop    = 1'b1;
						end
						SC_AR_ACK: r.ack_control = ACK_SET;
						SC_DR_ACK, SC_DR_NAK: begin
							if (rd_mode && pos < xfer_len) begin
								r.rx_valid = 1'b1;
								r.rx_index = pos[7:0];
								r.rx_byte  = it.rx_data;
								pos        = pos + 9'd1;
							end
							if (it.bus_status == SC_DR_NAK) begin
								r.set_stop = 1'b1;
								busy       = 1'b0;
							end else if (pos >= xfer_len ||
									(abort_zero && pos == 9'd1 && it.rx_data == 8'h00)) begin
								r.ack_control = ACK_CLEAR;
							end else begin
								r.ack_control = ACK_SET;
							end
						end
						SC_AR_NAK: begin
							raise(ERR_NOSLAVE, r);
							r.set_stop = 1'b1;
						end
						default: begin
							raise(ERR_UNEXP, r);
							unexp_code    = it.bus_status;
							r.clear_start = 1'b1;
						end
					endcase
				end
				default: begin
					if (busy) begin
						r.status = ERR_BUSY;
					end else if (pend_err != ERR_NONE) begin
						r.status = pend_err;
						last_err = pend_err;
						pend_err = ERR_NONE;
					end
				end
			endcase
			r.busy_res = busy;
			return r;
		endfunction

		function void note_item(kind_t k, item_t it);
			pending_results.push_back(predict_result(k, it));
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task cmp(string field, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
					checked, field, got, want));
		endtask

		task check_result(logic [OUT_DATA_W-1:0] word);
			res_t got;
			res_t want;
			got = res_t'(word[RES_W-1:0]);
			if (pending_results.size() == 0) begin
				report($sformatf("result transfer 0x%0h with nothing expected", word));
				return;
			end
			want = pending_results.pop_front();
			cmp("pad", word[OUT_DATA_W-1:RES_W], 0);
			cmp("set_start", got.set_start, want.set_start);
			cmp("clear_start", got.clear_start, want.clear_start);
			cmp("set_stop", got.set_stop, want.set_stop);
			cmp("ack_control", got.ack_control, want.ack_control);
			cmp("tx_valid", got.tx_valid, want.tx_valid);
			cmp("tx_byte", got.tx_byte, want.tx_byte);
			cmp("rx_valid", got.rx_valid, want.rx_valid);
			cmp("rx_index", got.rx_index, want.rx_index);
			cmp("rx_byte", got.rx_byte, want.rx_byte);
			cmp("status", got.status, want.status);
			cmp("busy_res", got.busy_res, want.busy_res);
			checked++;
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;

	transfer_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int n_items       = 0;
	int kind_count [4];
	int cycles        = 0;

	i2c_master_transfer_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic item_t rand_item();
		item_t it;
		it.buf_index     = 8'($urandom);
		it.buf_byte      = 8'($urandom);
		it.transfer_type = 3'($urandom);
		it.address       = 8'($urandom);
		it.length        = 9'($urandom_range(256));
		it.bus_status    = 8'($urandom);
		it.rx_data       = 8'($urandom);
		return it;
	endfunction

	// one input transfer; called and returns at a falling edge
	task automatic push(input kind_t k, input item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {{(IN_DATA_W - $bits(item_t)){1'b0}}, it};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(k, it);
		n_items++;
		kind_count[k]++;
		@(negedge clk);
	endtask

	// never let a data send read a buffer entry that was not loaded
	task automatic send(input kind_t k, input item_t it);
		item_t fill;
		if (k == KIND_EVENT && (it.bus_status == SC_AW_ACK || it.bus_status == SC_DW_ACK) &&
				!sb.rd_mode && sb.pos < sb.xfer_len && !sb.loaded[sb.pos[7:0]]) begin
			fill           = rand_item();
			fill.buf_index = sb.pos[7:0];
			push(KIND_LOAD, fill);
		end
		push(k, it);
	endtask

	task automatic load(input logic [7:0] idx, input logic [7:0] b);
		item_t it;
		it           = rand_item();
		it.buf_index = idx;
		it.buf_byte  = b;
		send(KIND_LOAD, it);
	endtask

	task automatic start(input logic [2:0] tt, input logic [7:0] addr, input logic [8:0] len);
		item_t it;
		it               = rand_item();
		it.transfer_type = tt;
		it.address       = addr;
		it.length        = len;
		send(KIND_START, it);
	endtask

	task automatic bus_event(input logic [7:0] code, input logic [7:0] rx);
		item_t it;
		it            = rand_item();
		it.bus_status = code;
		it.rx_data    = rx;
		send(KIND_EVENT, it);
	endtask

	task automatic poll();
		send(KIND_POLL, rand_item());
	endtask

	function automatic logic [8:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r == 0)
			return 9'd256;
		else if (r < 4)
			return 9'($urandom_range(40, 9));
		return 9'($urandom_range(8));
	endfunction

	function automatic logic [7:0] pick_fault();
		case ($urandom_range(3))
			0: return SC_DW_NAK;
			1: return SC_ARB_LOST;
			2: return SC_BUS_ERR;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic write_run();
		logic [8:0] n;
		n = pick_len();
		for (int i = 0; i < n; i++)
			if ($urandom_range(3) != 0)
				load(8'(i), 8'($urandom));
		start($urandom_range(1) ? TT_WRITE : TT_WRITE_NS, 8'($urandom), n);
		bus_event($urandom_range(1) ? SC_START : SC_RSTART, 8'($urandom));
		if ($urandom_range(9) == 0) begin
			bus_event(SC_AW_NAK, 8'($urandom));
			poll();
			return;
		end
		for (int i = 0; i <= n; i++) begin
			if ($urandom_range(29) == 0) begin
				bus_event(pick_fault(), 8'($urandom));
				poll();
				return;
			end
			bus_event(i == 0 ? SC_AW_ACK : SC_DW_ACK, 8'($urandom));
		end
		poll();
	endtask

	task automatic read_run();
		logic [8:0] n;
		logic [2:0] tt;
		logic [7:0] rx;
		n  = pick_len();
		tt = $urandom_range(1) ? TT_READ : TT_READ_ABORT;
		start(tt, 8'($urandom), n);
		bus_event($urandom_range(1) ? SC_START : SC_RSTART, 8'($urandom));
		if ($urandom_range(9) == 0) begin
			bus_event(SC_AR_NAK, 8'($urandom));
			poll();
			return;
		end
		bus_event(SC_AR_ACK, 8'($urandom));
		for (int i = 0; i < n; i++) begin
			rx = 8'($urandom);
			if (i == 0 && tt == TT_READ_ABORT && $urandom_range(1))
				rx = 8'h00;
			if ($urandom_range(39) == 0) begin
				bus_event(pick_fault(), rx);
				poll();
				return;
			end
			bus_event(i == n - 1 ? SC_DR_NAK : SC_DR_ACK, rx);
		end
		// reads past the length, or a plain finish for an empty read
		if (n == 0 || $urandom_range(5) == 0)
			bus_event($urandom_range(1) ? SC_DR_ACK : SC_DR_NAK, 8'($urandom));
		poll();
	endtask

	task automatic noise();
		item_t it;
		kind_t k;
		it = rand_item();
		k  = kind_t'($urandom_range(3));
		if ($urandom_range(1))
			it.bus_status = {5'($urandom_range(11)), 3'b000};
		send(k, it);
	endtask

	initial begin
		int n_directed;
		int waited;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_LOAD;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle events, unsupported type, busy and pending-error refusals,
		// an abort read, data send in read mode, abort on a zero first byte, every fault code
		poll();
		bus_event(SC_AW_ACK, 8'h00);
		load(8'h00, 8'hff);
		load(8'hff, 8'h00);
		start(3'd7, 8'hff, 9'd256);
		start(TT_WRITE, 8'hff, 9'd1);
		start(TT_READ, 8'h00, 9'd1);
		poll();
		bus_event(SC_START, 8'hff);
		bus_event(SC_AW_ACK, 8'h00);
		bus_event(SC_DW_ACK, 8'h00);
		start(TT_READ_ABORT, 8'h00, 9'd3);
		bus_event(SC_RSTART, 8'h00);
		bus_event(SC_AR_ACK, 8'h00);
		bus_event(SC_DW_ACK, 8'h00);
		bus_event(SC_DR_ACK, 8'h00);
		bus_event(SC_DR_NAK, 8'hff);
		start(TT_WRITE_NS, 8'h55, 9'd0);
		bus_event(SC_AW_NAK, 8'h00);
		start(TT_READ, 8'haa, 9'd2);
		bus_event(SC_ARB_LOST, 8'h00);
		poll();
		bus_event(SC_BUS_ERR, 8'h00);
		bus_event(SC_AR_NAK, 8'h00);
		bus_event(SC_DW_NAK, 8'h00);
		bus_event(8'hff, 8'hff);
		poll();
		n_directed = n_items;

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 49; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 49; end
				default: begin send_idle_pct = 17; stall_pct = 17; end
			endcase
			while (n_items < n_directed + (p + 1) * ITEMS_PER_PHASE) begin
				case ($urandom_range(9))
					0, 1, 2, 3: write_run();
					4, 5, 6, 7: read_run();
					default: repeat ($urandom_range(4, 1)) noise();
				endcase
			end
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.outstanding()));

		$display("sent %0d items: %0d loads, %0d starts, %0d bus events, %0d polls",
			n_items, kind_count[KIND_LOAD], kind_count[KIND_START],
			kind_count[KIND_EVENT], kind_count[KIND_POLL]);
		$display("checked %0d results across four idle/stall mixes, %0d mismatches",
			sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
